[rtl/atc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_pkg
// Types and constants shared by the alarm table controller and its testbench.
// ----------------------------------------------------------------------------
package atc_pkg;

	localparam int SLOTS_DEFAULT = 8;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_SELECT = 3'd1;
	localparam logic [2:0] OP_TOGGLE = 3'd2;
	localparam logic [2:0] OP_EDIT   = 3'd3;
	localparam logic [2:0] OP_ADJUST = 3'd4;
	localparam logic [2:0] OP_DISMISS = 3'd5;
	localparam logic [2:0] OP_LOAD   = 3'd6;
	localparam logic [2:0] OP_LEAVE  = 3'd7;

	localparam logic [1:0] EDIT_NONE    = 2'd0;
	localparam logic [1:0] EDIT_HOURS   = 2'd1;
	localparam logic [1:0] EDIT_MINUTES = 2'd2;

	localparam logic [9:0]  HOURS_PER_DAY = 10'd24;
	localparam logic [9:0]  MIN_PER_HOUR  = 10'd60;
	localparam logic [11:0] MIN_PER_DAY   = 12'd1440;
	localparam logic [9:0]  HOUR_BIAS     = 10'd144;
	localparam logic [9:0]  MINUTE_BIAS   = 10'd180;
	localparam logic [10:0] TIMEOUT_RESET = 11'd1;

	typedef struct packed {
		logic [2:0]        op;
		logic [4:0]        time_hour;
		logic [5:0]        time_minute;
		logic signed [7:0] adjust_delta;
		logic [2:0]        entry_index;
		logic [4:0]        entry_hours;
		logic [5:0]        entry_minutes;
		logic              entry_enabled;
		logic              entry_valid;
	} req_t;

	typedef struct packed {
		logic       accepted;
		logic       ring_started;
		logic       ringing;
		logic [2:0] ringing_slot;
		logic [2:0] selected_slot;
		logic [4:0] selected_hours;
		logic [5:0] selected_minutes;
		logic       selected_enabled;
		logic [1:0] edit_field;
		logic       save_pending;
	} rsp_t;

	typedef struct packed {
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic        enabled;
		logic        fired;
		logic [10:0] guard;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/atc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module atc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

[rtl/alarm_table_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_table_controller_top
// Alarm table with tick matching, selection, editing and ring timeout.
// ----------------------------------------------------------------------------
// usage:
//   raise start with a request while busy is low; the request is taken at
//   that edge and busy stays high until the result has been shown
//   the result is on result for one cycle with done high; it cannot be held
//   tick and select next walk every slot through the entry RAM, one slot a
//   cycle: tick goes through decode, scan, order and output states, select
//   next adds its extra bound step between scan and order
//   toggle and enabled adjust do a read-modify-write, edit button a read only
//   dismiss, load entry, leave mode and refused adjust go from decode to order
//   the ring timeout register is written on cfg_valid, cfg_ready is always
//   high; write it only while busy is low
//   reset clears all control state; every slot reads as zero until written,
//   tracked by one valid flop per slot, so no clearing pass is needed
// ----------------------------------------------------------------------------
module alarm_table_controller_top #(
	parameter int ALARM_SLOTS = atc_pkg::SLOTS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  atc_pkg::req_t request,
	output logic          done,
	output atc_pkg::rsp_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [10:0]   cfg_data
);
	import atc_pkg::*;

	localparam int IDX_W = ALARM_SLOTS > 1 ? $clog2(ALARM_SLOTS) : 1;
	localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(ALARM_SLOTS - 1);
	localparam logic [CNT_W-1:0] NSLOT = CNT_W'(ALARM_SLOTS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_MOD  = 3'd4;
	localparam logic [2:0] S_ORD  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	function automatic logic [9:0] wrap_mod(input logic [9:0] v, input logic [9:0] m);
		logic [9:0] r;
		logic [9:0] s;
		r = v;
		for (int k = 3; k >= 0; k--) begin
			s = m << k;
			if (r >= s) begin
				r = r - s;
			end
		end
		return r;
	endfunction

	logic [2:0]             state_q;
	req_t                   req_q;
	logic [IDX_W-1:0]       sel_q;
	logic [1:0]             edit_q;
	logic                   ring_q;
	logic [IDX_W-1:0]       ring_idx_q;
	logic [10:0]            ring_start_q;
	logic                   changed_q;
	logic [10:0]            timeout_q;
	logic [ALARM_SLOTS-1:0] modified_q;
	logic [ALARM_SLOTS-1:0] valid_q;
	logic                   acc_q;
	logic                   started_q;
	logic                   arm_q;
	logic [10:0]            now_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       proc_q;
	logic [CNT_W-1:0]       lim_q;
	logic                   rdv_s1;

	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	entry_t                 wr_data;
	entry_t                 rd_data;
	entry_t                 ent;

	logic [4:0]             th_w;
	logic [5:0]             tm_w;
	logic [10:0]            now_c;
	logic [11:0]            diff_c;
	logic                   timeout_hit;
	logic                   fired_keep;
	logic                   hit;
	entry_t                 scan_ent;
	entry_t                 load_ent;
	entry_t                 toggle_ent;
	entry_t                 adj_ent;
	logic                   adj_change;
	logic [9:0]             delta_x;
	logic [9:0]             hours_v;
	logic [9:0]             minutes_v;
	logic [IDX_W+2:0]       eidx_x;
	logic                   eidx_ok;
	logic [IDX_W-1:0]       eidx;
	logic [CNT_W-1:0]       lim_c;
	logic [CNT_W-1:0]       sel_x;
	logic [CNT_W-1:0]       next_c;
	logic [IDX_W+2:0]       sel_o;
	logic [IDX_W+2:0]       ring_o;

	atc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ALARM_SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign busy      = state_q != S_IDLE;
	assign done      = state_q == S_OUT;
	assign cfg_ready = 1'b1;

	assign ent = rdv_s1 ? rd_data : '0;

	// minute of day for tick
	assign th_w   = (req_q.time_hour >= 5'd24) ? req_q.time_hour - 5'd24 : req_q.time_hour;
	assign tm_w   = (req_q.time_minute >= 6'd60) ? req_q.time_minute - 6'd60
		: req_q.time_minute;
	assign now_c  = 11'(th_w) * 11'd60 + 11'(tm_w);
	assign diff_c = (now_c >= ring_start_q) ? 12'(now_c) - 12'(ring_start_q)
		: 12'(now_c) + MIN_PER_DAY - 12'(ring_start_q);
	assign timeout_hit = diff_c >= 12'(timeout_q);

	// per-slot guard and match during the scan
	assign fired_keep = ent.fired && (ent.guard == now_q);
	assign hit = arm_q && ent.enabled && !fired_keep && (ent.hours == req_q.time_hour)
		&& (ent.minutes == req_q.time_minute);
	always_comb begin
		scan_ent       = ent;
		scan_ent.fired = hit || fired_keep;
		scan_ent.guard = hit ? now_q : ent.guard;
	end

	always_comb begin
		load_ent = '0;
		if (req_q.entry_valid) begin
			load_ent.hours   = req_q.entry_hours;
			load_ent.minutes = req_q.entry_minutes;
			load_ent.enabled = req_q.entry_enabled;
		end
	end
	assign eidx_x  = {IDX_W'(0), req_q.entry_index};
	assign eidx_ok = eidx_x < (IDX_W + 3)'(ALARM_SLOTS);
	assign eidx    = eidx_x[IDX_W-1:0];

	always_comb begin
		toggle_ent         = ent;
		toggle_ent.enabled = ~ent.enabled;
		toggle_ent.fired   = 1'b0;
		toggle_ent.guard   = '0;
	end

	assign delta_x   = {{2{req_q.adjust_delta[7]}}, req_q.adjust_delta};
	assign hours_v   = wrap_mod(10'(ent.hours) + delta_x + HOUR_BIAS, HOURS_PER_DAY);
	assign minutes_v = wrap_mod(10'(ent.minutes) + delta_x + MINUTE_BIAS, MIN_PER_HOUR);
	always_comb begin
		adj_ent       = ent;
		adj_ent.fired = 1'b0;
		adj_ent.guard = '0;
		if (edit_q == EDIT_HOURS) begin
			adj_ent.hours = hours_v[4:0];
			adj_change    = hours_v[4:0] != ent.hours;
		end else begin
			adj_ent.minutes = minutes_v[5:0];
			adj_change      = minutes_v[5:0] != ent.minutes;
		end
	end

	// select next bound
	assign lim_c  = (lim_q > LAST) ? LAST : lim_q;
	assign sel_x  = CNT_W'(sel_q);
	assign next_c = (sel_x >= lim_c) ? '0 : sel_x + CNT_W'(1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = sel_q;
		wr_en   = 1'b0;
		wr_addr = sel_q;
		wr_data = toggle_ent;
		unique case (state_q)
			S_DEC: begin
				case (req_q.op)
					OP_TICK, OP_SELECT: begin
						rd_en   = 1'b1;
						rd_addr = '0;
					end
					OP_TOGGLE, OP_EDIT, OP_ADJUST: begin
						rd_en = 1'b1;
					end
					OP_LOAD: begin
						wr_en   = eidx_ok;
						wr_addr = eidx;
						wr_data = load_ent;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				rd_en   = cnt_q < NSLOT;
				rd_addr = cnt_q[IDX_W-1:0];
				wr_en   = req_q.op == OP_TICK;
				wr_addr = proc_q;
				wr_data = scan_ent;
			end
			S_MOD: begin
				if (req_q.op == OP_TOGGLE) begin
					wr_en = 1'b1;
				end else if (req_q.op == OP_ADJUST) begin
					wr_en   = adj_change;
					wr_data = adj_ent;
				end
			end
			S_ORD: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sel_q        <= '0;
			edit_q       <= EDIT_NONE;
			ring_q       <= 1'b0;
			ring_idx_q   <= '0;
			ring_start_q <= '0;
			changed_q    <= 1'b0;
			timeout_q    <= TIMEOUT_RESET;
			modified_q   <= '0;
			valid_q      <= '0;
			rdv_s1       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rdv_s1 <= valid_q[rd_addr];
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					case (req_q.op)
						OP_TICK: begin
							state_q <= S_SCAN;
							if (ring_q && timeout_hit) begin
								ring_q       <= 1'b0;
								ring_idx_q   <= '0;
								ring_start_q <= '0;
							end
						end
						OP_SELECT: state_q <= S_SCAN;
						OP_TOGGLE, OP_EDIT: state_q <= S_MOD;
						OP_ADJUST: begin
							state_q <= (edit_q != EDIT_NONE) ? S_MOD : S_ORD;
						end
						OP_DISMISS: begin
							state_q      <= S_ORD;
							ring_q       <= 1'b0;
							ring_idx_q   <= '0;
							ring_start_q <= '0;
						end
						OP_LOAD: begin
							state_q <= S_ORD;
							if (eidx_ok) begin
								modified_q[eidx] <= req_q.entry_valid;
								changed_q        <= 1'b0;
							end
						end
						default: begin
							state_q   <= S_ORD;
							changed_q <= 1'b0;
							edit_q    <= EDIT_NONE;
						end
					endcase
				end
				S_SCAN: begin
					if (req_q.op == OP_TICK && hit) begin
						ring_q       <= 1'b1;
						ring_idx_q   <= proc_q;
						ring_start_q <= now_q;
						edit_q       <= EDIT_NONE;
					end
					if (CNT_W'(proc_q) == LAST) begin
						state_q <= (req_q.op == OP_TICK) ? S_ORD : S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_ORD;
					if (sel_x > lim_c) begin
						sel_q  <= lim_c[IDX_W-1:0];
						edit_q <= EDIT_NONE;
					end else if (!(lim_c == '0 && sel_x == '0) && next_c != sel_x) begin
						sel_q  <= next_c[IDX_W-1:0];
						edit_q <= EDIT_NONE;
					end
				end
				S_MOD: begin
					state_q <= S_ORD;
					if (req_q.op == OP_TOGGLE) begin
						modified_q[sel_q] <= 1'b1;
						changed_q         <= 1'b1;
						if (!ent.enabled) begin
							edit_q <= EDIT_NONE;
						end
					end else if (req_q.op == OP_EDIT) begin
						if (!(ent.enabled && edit_q == EDIT_NONE)) begin
							edit_q <= (edit_q == EDIT_NONE) ? EDIT_HOURS
								: (edit_q == EDIT_HOURS) ? EDIT_MINUTES : EDIT_NONE;
						end
					end else if (adj_change) begin
						modified_q[sel_q] <= 1'b1;
						changed_q         <= 1'b1;
					end
				end
				S_ORD: state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and scan bookkeeping
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request;
		end
		unique case (state_q)
			S_DEC: begin
				now_q     <= now_c;
				arm_q     <= !ring_q;
				cnt_q     <= CNT_W'(1);
				proc_q    <= '0;
				lim_q     <= '0;
				started_q <= 1'b0;
				case (req_q.op)
					OP_DISMISS: acc_q <= ring_q;
					OP_LOAD:    acc_q <= eidx_ok;
					OP_LEAVE:   acc_q <= changed_q;
					default:    acc_q <= 1'b0;
				endcase
			end
			S_SCAN: begin
				cnt_q  <= cnt_q + CNT_W'(1);
				proc_q <= proc_q + IDX_W'(1);
				if (modified_q[proc_q]) begin
					lim_q <= CNT_W'(proc_q) + CNT_W'(1);
				end
				if (req_q.op == OP_TICK && hit) begin
					arm_q     <= 1'b0;
					started_q <= 1'b1;
					acc_q     <= 1'b1;
				end
			end
			S_FIN: begin
				acc_q <= (sel_x > lim_c)
					|| (!(lim_c == '0 && sel_x == '0) && next_c != sel_x);
			end
			S_MOD: begin
				case (req_q.op)
					OP_TOGGLE: acc_q <= ~ent.enabled;
					OP_EDIT:   acc_q <= !(ent.enabled && edit_q == EDIT_NONE);
					default:   acc_q <= 1'b1;
				endcase
			end
			default: begin
			end
		endcase
	end

	assign sel_o  = {3'b000, sel_q};
	assign ring_o = {3'b000, ring_idx_q};

	always_comb begin
		result.accepted         = acc_q;
		result.ring_started     = started_q;
		result.ringing          = ring_q;
		result.ringing_slot     = ring_q ? ring_o[2:0] : 3'b000;
		result.selected_slot    = sel_o[2:0];
		result.selected_hours   = ent.hours;
		result.selected_minutes = ent.minutes;
		result.selected_enabled = ent.enabled;
		result.edit_field       = edit_q;
		result.save_pending     = changed_q;
	end

`ifndef SYNTHESIS
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(sel_q) < NSLOT)
		else $error("selected slot out of range");
	a_ring_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(ring_idx_q) < NSLOT)
		else $error("ringing slot out of range");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken without going busy");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block stays busy after result");
	a_no_ring_start: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.ring_started |-> result.ringing && req_q.op == OP_TICK)
		else $error("ring start without ringing tick");
`endif
endmodule

[tb/tb_alarm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alarm_checker
// Watches the request, result and timeout-write channels of the alarm table
// controller, keeps its own copy of the table and compares every result.
// ----------------------------------------------------------------------------
module tb_alarm_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  atc_pkg::req_t request,
	input  logic          done,
	input  atc_pkg::rsp_t result,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic [10:0]   cfg_data,
	output int            fail_count,
	output int            pending,
	output int            result_count
);
	import atc_pkg::*;

	localparam int N = 8;

	logic [4:0]  tab_hours [N];
	logic [5:0]  tab_minutes [N];
	logic        tab_enabled [N];
	logic        tab_modified [N];
	logic        tab_fired [N];
	logic [10:0] tab_guard [N];
	logic [2:0]  sel_idx;
	logic [1:0]  edit_st;
	logic        ring_on;
	logic [2:0]  ring_idx;
	logic [10:0] ring_from;
	logic        changed;
	logic [10:0] timeout_min;

	rsp_t expected_results [$];
	int   mismatch_count;

	assign pending = expected_results.size();

	function automatic logic [2:0] select_bound();
		int lim;
		lim = 0;
		for (int i = N - 1; i >= 0; i--)
			if (tab_modified[i] && lim == 0) lim = i + 1;
		if (lim > N - 1) lim = N - 1;
		return 3'(lim);
	endfunction

	function automatic int wrapped(int v, int m);
		v = v % m;
		if (v < 0) v += m;
		return v;
	endfunction

	task automatic forget_guard(int i);
		tab_fired[i] = 1'b0;
		tab_guard[i] = '0;
	endtask

	task automatic stop_ring();
		ring_on = 1'b0;
		ring_idx = '0;
		ring_from = '0;
	endtask

	task automatic apply_event(input req_t rq, output rsp_t rs);
		logic ok;
		logic fired_now;
		int now;
		int diff;
		int s;
		int lim;
		int nv;
		ok = 1'b0;
		fired_now = 1'b0;
		s = sel_idx;
		case (rq.op)
			OP_TICK: begin
				now = (rq.time_hour % 24) * 60 + (rq.time_minute % 60);
				for (int i = 0; i < N; i++)
					if (tab_fired[i] && tab_guard[i] != now) tab_fired[i] = 1'b0;
				if (!ring_on) begin
					for (int i = 0; i < N; i++) begin
						if (!fired_now && tab_enabled[i] && !tab_fired[i] &&
							tab_hours[i] == rq.time_hour && tab_minutes[i] == rq.time_minute) begin
							tab_fired[i] = 1'b1;
							tab_guard[i] = 11'(now);
							ring_on = 1'b1;
							ring_idx = 3'(i);
							ring_from = 11'(now);
							edit_st = EDIT_NONE;
							fired_now = 1'b1;
						end
					end
				end else begin
					diff = (now + 1440 - (ring_from % 1440)) % 1440;
					if (diff >= timeout_min) stop_ring();
				end
				ok = fired_now;
			end
			OP_SELECT: begin
				lim = select_bound();
				if (s > lim) begin
					sel_idx = 3'(lim);
					edit_st = EDIT_NONE;
					ok = 1'b1;
				end else if (!(lim == 0 && s == 0)) begin
					nv = (s >= lim) ? 0 : s + 1;
					if (nv != s) begin
						sel_idx = 3'(nv);
						edit_st = EDIT_NONE;
						ok = 1'b1;
					end
				end
			end
			OP_TOGGLE: begin
				tab_enabled[s] = !tab_enabled[s];
				if (tab_enabled[s]) edit_st = EDIT_NONE;
				tab_modified[s] = 1'b1;
				changed = 1'b1;
				forget_guard(s);
				ok = tab_enabled[s];
			end
			OP_EDIT: begin
				if (!(tab_enabled[s] && edit_st == EDIT_NONE)) begin
					edit_st = (edit_st == EDIT_NONE) ? EDIT_HOURS :
						(edit_st == EDIT_HOURS) ? EDIT_MINUTES : EDIT_NONE;
					ok = 1'b1;
				end
			end
			OP_ADJUST: begin
				if (edit_st != EDIT_NONE) begin
					if (edit_st == EDIT_HOURS) begin
						nv = wrapped(int'(tab_hours[s]) + int'(rq.adjust_delta), 24);
						if (nv != tab_hours[s]) begin
							tab_hours[s] = 5'(nv);
							tab_modified[s] = 1'b1;
							changed = 1'b1;
							forget_guard(s);
						end
					end else if (edit_st == EDIT_MINUTES) begin
						nv = wrapped(int'(tab_minutes[s]) + int'(rq.adjust_delta), 60);
						if (nv != tab_minutes[s]) begin
							tab_minutes[s] = 6'(nv);
							tab_modified[s] = 1'b1;
							changed = 1'b1;
							forget_guard(s);
						end
					end
					ok = 1'b1;
				end
			end
			OP_DISMISS: begin
				ok = ring_on;
				if (ring_on) stop_ring();
			end
			OP_LOAD: begin
				s = rq.entry_index;
				if (rq.entry_valid) begin
					tab_hours[s] = rq.entry_hours;
					tab_minutes[s] = rq.entry_minutes;
					tab_enabled[s] = rq.entry_enabled;
					tab_modified[s] = 1'b1;
				end else begin
					tab_hours[s] = '0;
					tab_minutes[s] = '0;
					tab_enabled[s] = 1'b0;
					tab_modified[s] = 1'b0;
				end
				forget_guard(s);
				changed = 1'b0;
				ok = 1'b1;
			end
			default: begin
				ok = changed;
				changed = 1'b0;
				edit_st = EDIT_NONE;
			end
		endcase
		s = sel_idx;
		rs.accepted = ok;
		rs.ring_started = fired_now;
		rs.ringing = ring_on;
		rs.ringing_slot = ring_on ? ring_idx : 3'd0;
		rs.selected_slot = sel_idx;
		rs.selected_hours = tab_hours[s];
		rs.selected_minutes = tab_minutes[s];
		rs.selected_enabled = tab_enabled[s];
		rs.edit_field = edit_st;
		rs.save_pending = changed;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				tab_hours[i] = '0;
				tab_minutes[i] = '0;
				tab_enabled[i] = 1'b0;
				tab_modified[i] = 1'b0;
				tab_fired[i] = 1'b0;
				tab_guard[i] = '0;
			end
			sel_idx = '0;
			edit_st = EDIT_NONE;
			stop_ring();
			changed = 1'b0;
			timeout_min = TIMEOUT_RESET;
			expected_results.delete();
			fail_count = 0;
			mismatch_count = 0;
			result_count = 0;
		end else begin
			if (done) begin
				result_count++;
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("error: result %p with no request outstanding", result);
				end else begin
					want = expected_results.pop_front();
					if (want !== result) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected %p, actual %p", want, result);
					end
				end
			end
			if (cfg_valid && cfg_ready) timeout_min = cfg_data;
			if (start && !busy) begin
				apply_event(request, want);
				expected_results.push_back(want);
			end
		end
	end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random alarm events with bursty gaps into the alarm
// table controller, rewrites the ring timeout between phases and reports.
// ----------------------------------------------------------------------------
module tb_top;
	import atc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REQ_W = $bits(req_t);

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        request;
	logic        done;
	rsp_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;
	int          fail_count;
	int          pending;
	int          result_count;
	int          idle_cycles;
	int          event_count;
	int          timeout_writes;

	alarm_table_controller_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	tb_alarm_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending),
		.result_count(result_count)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_event(input req_t rq);
		start <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 1'b0;
		event_count++;
		@(posedge clk);
	endtask

	task automatic idle_wait();
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [10:0] v);
		idle_wait();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		timeout_writes++;
		@(posedge clk);
	endtask

	function automatic req_t noise_req();
		req_t rq;
		rq = req_t'(REQ_W'({$urandom, $urandom}));
		return rq;
	endfunction

	function automatic req_t make_req(logic [2:0] op);
		req_t rq;
		rq = noise_req();
		rq.op = op;
		if ($urandom_range(0, 9) != 0) begin
			rq.time_hour = 5'($urandom_range(0, 23));
			rq.time_minute = 6'($urandom_range(0, 59));
			rq.entry_hours = 5'($urandom_range(0, 23));
			rq.entry_minutes = 6'($urandom_range(0, 59));
		end
		if ($urandom_range(0, 3) != 0) rq.adjust_delta = 8'($signed($urandom_range(0, 6)) - 3);
		return rq;
	endfunction

	// alarm load followed by ticks at its time and just after it, mixed with other events
	task automatic ring_scenario();
		req_t rq;
		logic [4:0] h;
		logic [5:0] m;
		int n;
		h = 5'($urandom_range(0, 23));
		m = 6'($urandom_range(0, 59));
		rq = make_req(OP_LOAD);
		rq.entry_index = 3'($urandom_range(0, 7));
		rq.entry_hours = h;
		rq.entry_minutes = m;
		rq.entry_enabled = 1'b1;
		rq.entry_valid = 1'b1;
		send_event(rq);
		n = $urandom_range(2, 6);
		for (int k = 0; k < n; k++) begin
			rq = make_req($urandom_range(0, 2) != 0 ? OP_TICK : 3'($urandom_range(1, 7)));
			if (rq.op == OP_TICK) begin
				rq.time_hour = h;
				rq.time_minute = 6'((m + $urandom_range(0, 3)) % 60);
			end
			send_event(rq);
		end
	endtask

	// select, toggle, edit and adjust walk on the selected entry
	task automatic edit_scenario();
		int n;
		n = $urandom_range(3, 8);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: send_event(make_req(OP_SELECT));
				1: send_event(make_req(OP_TOGGLE));
				2, 3: send_event(make_req(OP_EDIT));
				default: send_event(make_req(OP_ADJUST));
			endcase
		end
	endtask

	task automatic random_phase(input int count);
		int burst;
		int done_here;
		done_here = 0;
		while (done_here < count) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst; b++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: ring_scenario();
					3, 4, 5: edit_scenario();
					6: send_event(noise_req());
					default: send_event(make_req(3'($urandom_range(0, 7))));
				endcase
				done_here++;
			end
			if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	initial begin
		req_t rq;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_cycles = 0;
		event_count = 0;
		timeout_writes = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table select, load extremes, tick match, timeout, edits
		send_event(make_req(OP_SELECT));
		send_event(make_req(OP_DISMISS));
		send_event(make_req(OP_ADJUST));
		rq = '0; rq.op = OP_LOAD; rq.entry_index = 3'd7; rq.entry_hours = 5'd31;
		rq.entry_minutes = 6'd63; rq.entry_enabled = 1'b1; rq.entry_valid = 1'b1;
		send_event(rq);
		rq = '0; rq.op = OP_TICK; rq.time_hour = 5'd31; rq.time_minute = 6'd63;
		send_event(rq);
		rq = '0; rq.op = OP_LOAD; rq.entry_hours = 5'd23; rq.entry_minutes = 6'd59;
		rq.entry_enabled = 1'b1; rq.entry_valid = 1'b1;
		send_event(rq);
		rq = '0; rq.op = OP_TICK; rq.time_hour = 5'd23; rq.time_minute = 6'd59;
		send_event(rq);
		send_event(rq);
		rq.time_hour = 5'd0; rq.time_minute = 6'd0;
		send_event(rq);
		send_event(make_req(OP_DISMISS));
		send_event(make_req(OP_EDIT));
		send_event(make_req(OP_TOGGLE));
		send_event(make_req(OP_EDIT));
		rq = '0; rq.op = OP_ADJUST; rq.adjust_delta = 8'sd127;
		send_event(rq);
		send_event(make_req(OP_EDIT));
		rq.adjust_delta = -8'sd128;
		send_event(rq);
		send_event(make_req(OP_EDIT));
		for (int k = 0; k < 8; k++) send_event(make_req(OP_SELECT));
		send_event(make_req(OP_LEAVE));
		send_event(make_req(OP_LEAVE));
		rq = '0; rq.op = OP_LOAD; rq.entry_index = 3'd7;
		send_event(rq);

		write_timeout(11'd1439);
		random_phase(80);
		write_timeout(11'd0);
		random_phase(80);
		write_timeout(11'd2047);
		random_phase(80);
		write_timeout(11'($urandom_range(2, 5)));
		random_phase(80);
		write_timeout(TIMEOUT_RESET);
		random_phase(70);

		idle_wait();
		$display("covered %0d events, %0d results, %0d ring timeout settings",
			event_count, result_count, timeout_writes);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
